// ===== rtl/core/fcml_pkg.sv =====
package fcml_pkg;

  localparam int DEF_MAX_CLASSES     = 64;
  localparam int DEF_MAX_DESCRIPTORS = 16;

  localparam logic [16:0] ONE        = 17'h10000;
  localparam logic [16:0] HALF       = 17'h08000;
  localparam logic [31:0] Q30        = 32'h4000_0000;
  localparam logic [16:0] LAMBDA_RST = 17'd39322;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_PROTO  = 2'd1;
  localparam logic [1:0] ACT_COUNT  = 2'd2;

  localparam logic [3:0] REG_LAMBDA  = 4'd0;
  localparam logic [3:0] REG_LEARN   = 4'd1;
  localparam logic [3:0] REG_DESC    = 4'd2;
  localparam logic [3:0] REG_UNKNOWN = 4'd3;

  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_LEN   = 2'd3;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_LOG = 2'd1;
  localparam logic [1:0] OP_EXP = 2'd2;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [39:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic        start;
    logic [16:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quo;
  } div_rsp_t;

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] nn;
    res  = '0;
    bitv = 64'h1 << 62;
    nn   = n;
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (nn >= res + bitv) begin
          nn  = nn - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // packed table of 2^(-2^(k-16)) in Q.30, entry k at bits [31k +: 31]
  function automatic logic [16*31-1:0] root_pack();
    logic [63:0]        t;
    logic [16*31-1:0]   tab;
    t = isqrt64(64'h1 << 59);
    tab = '0;
    tab[15*31 +: 31] = t[30:0];
    for (int k = 15; k > 0; k--) begin
      t = isqrt64(t << 30);
      tab[(k-1)*31 +: 31] = t[30:0];
    end
    return tab;
  endfunction

endpackage

// ===== rtl/core/fcml_if.sv =====
interface fcml_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  class_sel;
  logic [3:0]  element_index;
  logic [16:0] value;
  logic [15:0] member_count;
  logic        last;
  modport source (output valid, action, class_sel, element_index, value, member_count, last,
                  input ready);
  modport sink (input valid, action, class_sel, element_index, value, member_count, last,
                output ready);
endinterface

interface fcml_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  class_found;
  logic [16:0] best_degree;
  logic [1:0]  status;
  modport source (output valid, class_found, best_degree, status, input ready);
  modport sink (input valid, class_found, best_degree, status, output ready);
endinterface

interface fcml_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fcml_alu.sv =====
module fcml_alu
  import fcml_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic [16*31-1:0] ROOT_TAB = root_pack();

  logic        busy_r;
  logic        done_r;
  logic [1:0]  op_r;
  logic [4:0]  cnt_r;
  logic [31:0] y_r;
  logic [15:0] frac_r;
  logic [4:0]  pint_r;
  logic [15:0] e_r;
  logic [4:0]  ip_r;
  logic [39:0] res_r;

  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] prod;
  logic [31:0] sq;
  logic [4:0]  lead;
  logic [3:0]  k;

  assign k = cnt_r[3:0];

  always_comb begin
    lead = '0;
    for (int i = 0; i < 17; i++) begin
      if (req.a[i]) lead = 5'(i);
    end
  end

  always_comb begin
    if (busy_r && op_r == OP_LOG) begin
      ma = y_r;
      mb = y_r;
    end else if (busy_r) begin
      ma = y_r;
      mb = e_r[k] ? {1'b0, ROOT_TAB[k*31 +: 31]} : Q30;
    end else begin
      ma = req.a;
      mb = req.b;
    end
  end

  assign prod = ma * mb;
  assign sq   = prod[61:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        op_r  <= req.op;
        cnt_r <= '0;
        case (req.op)
          OP_MUL: begin
            res_r  <= prod[39:0];
            done_r <= 1'b1;
          end
          OP_LOG: begin
            // normalize into [1,2) in Q.30
            y_r    <= {15'd0, req.a[16:0]} << (5'd30 - lead);
            pint_r <= 5'd16 - lead;
            frac_r <= '0;
            busy_r <= 1'b1;
          end
          OP_EXP: begin
            if (req.a[31:16] > 16'd16) begin
              res_r  <= '0;
              done_r <= 1'b1;
            end else begin
              y_r    <= Q30;
              e_r    <= req.a[15:0];
              ip_r   <= req.a[20:16];
              busy_r <= 1'b1;
            end
          end
          default: begin
            res_r  <= '0;
            done_r <= 1'b1;
          end
        endcase
      end else if (busy_r) begin
        if (cnt_r == 5'd16) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (op_r == OP_LOG) begin
            res_r <= 40'({pint_r, 16'd0} - {5'd0, frac_r});
          end else begin
            res_r <= 40'(y_r >> (6'd14 + {1'b0, ip_r}));
          end
        end else begin
          cnt_r <= cnt_r + 5'd1;
          if (op_r == OP_LOG) begin
            if (sq[31]) begin
              frac_r[4'd15 - k] <= 1'b1;
              y_r <= sq >> 1;
            end else begin
              y_r <= sq;
            end
          end else begin
            y_r <= sq;
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// ===== rtl/core/fcml_div.sv =====
module fcml_div
  import fcml_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [16:0] n_r;
  logic [15:0] den_r;
  logic [15:0] rem_r;
  logic [16:0] q_r;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_r, n_r[16]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd16;
        n_r    <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        // one quotient bit a cycle, restoring
        rem_r <= fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];
        q_r   <= {q_r[15:0], fits};
        n_r   <= n_r << 1;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

// ===== rtl/core/fuzzy_class_match_learn_top.sv =====
// fuzzy class matcher with on-line learning. sample beats (action 0) load the
// vector one element per cycle; prototype and count writes are taken the same way.
// the beat flagged last starts a match if the vector length equals the descriptor
// count (else it returns status len): a scan of the count table from class 1 up to
// the first empty one, then for each active class and descriptor one marginal
// degree built on the shared multiply unit: the prototype read, up to two log2 runs
// and one exp2 run, up to two multiplies and a fold of the term into min/max, plus
// a lambda mix and compare for each class. learning then writes a new class if
// there is room, or updates the winner's count and the running mean of each
// descriptor (17-bit serial divider). in_bus.ready is low for the whole match; the
// result beat waits in an output register, so a new input beat can be taken while
// it is pending. all values unsigned q1.16, 65536 = 1.0
module fuzzy_class_match_learn_top
  import fcml_pkg::*;
#(
  parameter int MAX_CLASSES     = DEF_MAX_CLASSES,
  parameter int MAX_DESCRIPTORS = DEF_MAX_DESCRIPTORS
) (
  input logic        clk,
  input logic        rst_n,
  fcml_in_if.sink    in_bus,
  fcml_out_if.source out_bus,
  fcml_cfg_if.sink   cfg_bus
);

  localparam int CLS_W  = $clog2(MAX_CLASSES);
  localparam int AW     = $clog2(MAX_CLASSES + 1);
  localparam int DW     = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int NW     = $clog2(MAX_DESCRIPTORS + 1);
  localparam int EW     = $clog2(MAX_DESCRIPTORS + 2);
  localparam int PDEPTH = MAX_CLASSES * MAX_DESCRIPTORS;
  localparam int PAW    = $clog2(PDEPTH);

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_PUSH    = 5'd1;
  localparam logic [4:0] S_SCAN_RD = 5'd2;
  localparam logic [4:0] S_SCAN_CK = 5'd3;
  localparam logic [4:0] S_PRD     = 5'd4;
  localparam logic [4:0] S_PLD     = 5'd5;
  localparam logic [4:0] S_LOG1    = 5'd6;
  localparam logic [4:0] S_MUL1    = 5'd7;
  localparam logic [4:0] S_LOG2    = 5'd8;
  localparam logic [4:0] S_MUL2    = 5'd9;
  localparam logic [4:0] S_EXP     = 5'd10;
  localparam logic [4:0] S_ACC     = 5'd11;
  localparam logic [4:0] S_G1      = 5'd12;
  localparam logic [4:0] S_G2      = 5'd13;
  localparam logic [4:0] S_CMP     = 5'd14;
  localparam logic [4:0] S_LRN     = 5'd15;
  localparam logic [4:0] S_NEW     = 5'd16;
  localparam logic [4:0] S_CRD     = 5'd17;
  localparam logic [4:0] S_CUPD    = 5'd18;
  localparam logic [4:0] S_URD     = 5'd19;
  localparam logic [4:0] S_ULD     = 5'd20;
  localparam logic [4:0] S_UDIV    = 5'd21;

  function automatic logic [PAW-1:0] paddr(logic [CLS_W-1:0] cc, logic [DW-1:0] dd);
    return PAW'(PAW'(cc) * PAW'(MAX_DESCRIPTORS) + PAW'(dd));
  endfunction

  // control
  logic [4:0]       state_r;
  logic             out_valid_r;
  logic [16:0]      lam_cfg_r;
  logic             learn_r;
  logic [4:0]       desc_cfg_r;
  logic [5:0]       unk_r;
  logic [EW-1:0]    elem_r;
  logic [AW-1:0]    act_r;
  logic             cnt_vld_r [MAX_CLASSES];
  logic             alu_iss_r;
  logic             div_iss_r;
  logic [CLS_W-1:0] scan_r;
  logic [CLS_W-1:0] c_r;
  logic [DW-1:0]    d_r;

  // datapath
  logic [NW-1:0]    nd_r;
  logic [16:0]      lam_r;
  logic [16:0]      samp_r [MAX_DESCRIPTORS];
  logic [16:0]      rho_r;
  logic [16:0]      x_r;
  logic [20:0]      log_r;
  logic [37:0]      e_acc_r;
  logic [16:0]      t_r;
  logic [16:0]      mn_r;
  logic [16:0]      mx_r;
  logic [34:0]      g_acc_r;
  logic [16:0]      g_r;
  logic [16:0]      best_r;
  logic [CLS_W-1:0] win_r;
  logic [15:0]      k_r;
  logic             neg_r;
  logic [16:0]      mag_r;
  logic [5:0]       res_cls_r;
  logic [16:0]      res_deg_r;
  logic [1:0]       res_st_r;
  logic [5:0]       out_cls_r;
  logic [16:0]      out_deg_r;
  logic [1:0]       out_st_r;

  // memories
  logic [16:0]      proto_mem [PDEPTH];
  logic [16:0]      proto_rd_r;
  logic [15:0]      cnt_mem [MAX_CLASSES];
  logic [15:0]      cnt_rd_r;
  logic             cnt_vld_rd_r;

  logic             pw_en;
  logic [PAW-1:0]   pw_addr;
  logic [16:0]      pw_data;
  logic [PAW-1:0]   pr_addr;
  logic             cw_en;
  logic [CLS_W-1:0] cw_addr;
  logic [15:0]      cw_data;
  logic [CLS_W-1:0] cr_addr;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             in_fire;
  logic             cfg_fire;
  logic             push_go;
  logic [16:0]      in_val;
  logic             cls_ok;
  logic             idx_ok;
  logic [EW-1:0]    n_c;
  logic [NW-1:0]    nd_c;
  logic [16:0]      lam_c;
  logic             d_last;
  logic [16:0]      x_c;
  logic             zero_c;
  logic             unk_hit;
  logic             cnt_zero;
  logic [15:0]      k_c;
  logic [16:0]      upd;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;
  // result register free this cycle
  assign push_go  = (state_r == S_PUSH) && (!out_valid_r || out_bus.ready);
  assign in_val   = (in_bus.value > ONE) ? ONE : in_bus.value;
  assign cls_ok   = int'(in_bus.class_sel) < MAX_CLASSES;
  assign idx_ok   = int'(in_bus.element_index) < MAX_DESCRIPTORS;

  // element count including this beat, saturating one past the maximum
  assign n_c  = (int'(elem_r) < MAX_DESCRIPTORS + 1) ? EW'(elem_r + EW'(1)) : elem_r;
  assign nd_c = (desc_cfg_r == 5'd0) ? NW'(1) :
                (int'(desc_cfg_r) > MAX_DESCRIPTORS) ? NW'(MAX_DESCRIPTORS) : NW'(desc_cfg_r);
  assign lam_c = (lam_cfg_r > ONE) ? ONE : lam_cfg_r;

  assign d_last   = NW'(d_r) == NW'(nd_r - NW'(1));
  assign x_c      = samp_r[d_r];
  // a zero base under a nonzero exponent kills the term
  assign zero_c   = (proto_rd_r == 17'd0 && x_c != 17'd0) ||
                    (proto_rd_r == ONE && x_c != ONE);
  assign unk_hit  = int'(win_r) == int'(unk_r);
  assign cnt_zero = !cnt_vld_rd_r || cnt_rd_r == 16'd0;
  assign k_c      = cnt_vld_rd_r ? ((cnt_rd_r == 16'hFFFF) ? cnt_rd_r : cnt_rd_r + 16'd1)
                                 : 16'd1;
  assign upd      = neg_r ? 17'(rho_r - div_rsp.quo) : 17'(rho_r + div_rsp.quo);

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid       = out_valid_r;
  assign out_bus.class_found = out_cls_r;
  assign out_bus.best_degree = out_deg_r;
  assign out_bus.status      = out_st_r;

  // shared unit requests
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    case (state_r)
      S_LOG1: begin
        alu_req.op = OP_LOG;
        alu_req.a  = 32'(rho_r);
      end
      S_MUL1: begin
        alu_req.a = 32'(x_r);
        alu_req.b = 32'(log_r);
      end
      S_LOG2: begin
        alu_req.op = OP_LOG;
        alu_req.a  = 32'(ONE - rho_r);
      end
      S_MUL2: begin
        alu_req.a = 32'(ONE - x_r);
        alu_req.b = 32'(log_r);
      end
      S_EXP: begin
        alu_req.op = OP_EXP;
        alu_req.a  = 32'(e_acc_r >> 16);
      end
      S_G1: begin
        alu_req.a = 32'(lam_r);
        alu_req.b = 32'(mn_r);
      end
      S_G2: begin
        alu_req.a = 32'(ONE - lam_r);
        alu_req.b = 32'(mx_r);
      end
      default: ;
    endcase
    if (state_r inside {S_LOG1, S_MUL1, S_LOG2, S_MUL2, S_EXP, S_G1, S_G2}) begin
      alu_req.start = !alu_iss_r;
    end
  end

  always_comb begin
    div_req.start = (state_r == S_UDIV) && !div_iss_r;
    div_req.num   = mag_r;
    div_req.den   = k_r;
  end

  fcml_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  fcml_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // memory ports
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = paddr(win_r, d_r);
    pw_data = upd;
    pr_addr = (state_r == S_URD) ? paddr(win_r, d_r) : paddr(c_r, d_r);
    cw_en   = 1'b0;
    cw_addr = win_r;
    cw_data = k_c;
    cr_addr = (state_r == S_CRD) ? win_r : scan_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_bus.action == ACT_PROTO && cls_ok && idx_ok) begin
          pw_en   = 1'b1;
          pw_addr = paddr(CLS_W'(in_bus.class_sel), DW'(in_bus.element_index));
          pw_data = in_val;
        end
        if (in_fire && in_bus.action == ACT_COUNT && cls_ok) begin
          cw_en   = 1'b1;
          cw_addr = CLS_W'(in_bus.class_sel);
          cw_data = in_bus.member_count;
        end
      end
      S_LRN: begin
        if (learn_r && unk_hit && int'(act_r) < MAX_CLASSES) begin
          cw_en   = 1'b1;
          cw_addr = CLS_W'(act_r);
          cw_data = 16'd2;
        end
      end
      S_NEW: begin
        pw_en   = 1'b1;
        pw_addr = paddr(CLS_W'(act_r), d_r);
        pw_data = 17'((18'(x_c) + 18'(HALF)) >> 1);
      end
      S_CUPD: cw_en = 1'b1;
      S_UDIV: pw_en = div_rsp.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_en) proto_mem[pw_addr] <= pw_data;
    proto_rd_r <= proto_mem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (cw_en) cnt_mem[cw_addr] <= cw_data;
    cnt_rd_r     <= cnt_mem[cr_addr];
    cnt_vld_rd_r <= cnt_vld_r[cr_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lam_cfg_r   <= LAMBDA_RST;
      learn_r     <= 1'b1;
      desc_cfg_r  <= 5'd16;
      unk_r       <= '0;
      elem_r      <= '0;
      act_r       <= '0;
      alu_iss_r   <= 1'b0;
      div_iss_r   <= 1'b0;
      scan_r      <= '0;
      c_r         <= '0;
      d_r         <= '0;
      for (int i = 0; i < MAX_CLASSES; i++) cnt_vld_r[i] <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_bus.index)
          REG_LAMBDA:  lam_cfg_r  <= cfg_bus.data;
          REG_LEARN:   learn_r    <= cfg_bus.data[0];
          REG_DESC:    desc_cfg_r <= cfg_bus.data[4:0];
          REG_UNKNOWN: unk_r      <= cfg_bus.data[5:0];
          default: ;
        endcase
      end
      // result register: load a new beat or drop the one taken
      if (push_go) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (alu_req.start) alu_iss_r <= 1'b1;
      if (alu_rsp.done) alu_iss_r <= 1'b0;
      if (div_req.start) div_iss_r <= 1'b1;
      if (div_rsp.done) div_iss_r <= 1'b0;
      if (cw_en) cnt_vld_r[cw_addr] <= 1'b1;

      case (state_r)
        S_IDLE: begin
          if (in_fire && in_bus.action == ACT_SAMPLE) begin
            if (idx_ok) samp_r[DW'(in_bus.element_index)] <= in_val;
            if (in_bus.last) begin
              elem_r <= '0;
              nd_r   <= nd_c;
              lam_r  <= lam_c;
              if (int'(n_c) != int'(nd_c)) begin
                res_cls_r <= '0;
                res_deg_r <= '0;
                res_st_r  <= ST_LEN;
                state_r   <= S_PUSH;
              end else begin
                scan_r  <= CLS_W'(1);
                state_r <= S_SCAN_RD;
              end
            end else begin
              elem_r <= n_c;
            end
          end
        end
        S_PUSH: begin
          if (push_go) begin
            out_cls_r <= res_cls_r;
            out_deg_r <= res_deg_r;
            out_st_r  <= res_st_r;
            state_r   <= S_IDLE;
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CK;
        S_SCAN_CK: begin
          // active count: first empty class from 1 up, else the full table
          if (cnt_zero || int'(scan_r) == MAX_CLASSES - 1) begin
            act_r   <= cnt_zero ? AW'(scan_r) : AW'(MAX_CLASSES);
            c_r     <= '0;
            d_r     <= '0;
            mn_r    <= ONE;
            mx_r    <= '0;
            state_r <= S_PRD;
          end else begin
            scan_r  <= scan_r + CLS_W'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_PRD: state_r <= S_PLD;
        S_PLD: begin
          rho_r   <= proto_rd_r;
          x_r     <= x_c;
          e_acc_r <= '0;
          if (zero_c) begin
            t_r     <= '0;
            state_r <= S_ACC;
          end else if (x_c != 17'd0) begin
            state_r <= S_LOG1;
          end else begin
            state_r <= S_LOG2;
          end
        end
        S_LOG1: begin
          if (alu_rsp.done) begin
            log_r   <= alu_rsp.res[20:0];
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (alu_rsp.done) begin
            e_acc_r <= alu_rsp.res[37:0];
            state_r <= (x_r != ONE) ? S_LOG2 : S_EXP;
          end
        end
        S_LOG2: begin
          if (alu_rsp.done) begin
            log_r   <= alu_rsp.res[20:0];
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (alu_rsp.done) begin
            e_acc_r <= e_acc_r + alu_rsp.res[37:0];
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (alu_rsp.done) begin
            t_r     <= alu_rsp.res[16:0];
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (t_r < mn_r) mn_r <= t_r;
          if (t_r > mx_r) mx_r <= t_r;
          if (d_last) begin
            state_r <= S_G1;
          end else begin
            d_r     <= d_r + DW'(1);
            state_r <= S_PRD;
          end
        end
        S_G1: begin
          if (alu_rsp.done) begin
            g_acc_r <= alu_rsp.res[34:0];
            state_r <= S_G2;
          end
        end
        S_G2: begin
          if (alu_rsp.done) begin
            g_r     <= 17'((g_acc_r + alu_rsp.res[34:0]) >> 16);
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          // strict compare keeps the lowest index on a tie
          if (c_r == '0 || g_r > best_r) begin
            best_r <= g_r;
            win_r  <= c_r;
          end
          if (AW'(c_r) == AW'(act_r - AW'(1))) begin
            state_r <= S_LRN;
          end else begin
            c_r     <= c_r + CLS_W'(1);
            d_r     <= '0;
            mn_r    <= ONE;
            mx_r    <= '0;
            state_r <= S_PRD;
          end
        end
        S_LRN: begin
          d_r       <= '0;
          res_cls_r <= 6'(win_r);
          res_deg_r <= best_r;
          res_st_r  <= ST_MATCH;
          if (!learn_r) begin
            state_r <= S_PUSH;
          end else if (unk_hit) begin
            if (int'(act_r) < MAX_CLASSES) begin
              res_st_r <= ST_NEW;
              state_r  <= S_NEW;
            end else begin
              res_st_r <= ST_FULL;
              state_r  <= S_PUSH;
            end
          end else begin
            state_r <= S_CRD;
          end
        end
        S_NEW: begin
          if (d_last) begin
            act_r   <= act_r + AW'(1);
            state_r <= S_PUSH;
          end else begin
            d_r <= d_r + DW'(1);
          end
        end
        S_CRD: state_r <= S_CUPD;
        S_CUPD: begin
          k_r     <= k_c;
          state_r <= S_URD;
        end
        S_URD: state_r <= S_ULD;
        S_ULD: begin
          rho_r   <= proto_rd_r;
          neg_r   <= x_c < proto_rd_r;
          mag_r   <= (x_c < proto_rd_r) ? 17'(proto_rd_r - x_c) : 17'(x_c - proto_rd_r);
          state_r <= S_UDIV;
        end
        S_UDIV: begin
          if (div_rsp.done) begin
            if (d_last) begin
              state_r <= S_PUSH;
            end else begin
              d_r     <= d_r + DW'(1);
              state_r <= S_URD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // shared unit answers only a request that was issued
  a_alu_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> alu_iss_r)
    else $error("alu result without a pending request");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_UDIV)
    else $error("divider result outside the update step");

  a_new_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NEW |-> act_r < AW'(MAX_CLASSES))
    else $error("new class written past the table");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && (!out_valid_r || out_bus.ready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("result beat not loaded");

endmodule
